// File: sv/purc_pkg.sv
// ----------------------------------------------------------------------------
// purc_pkg
// Shared constants, types and arithmetic helpers of the row-then-column
// phase unwrapper.
// ----------------------------------------------------------------------------
package purc_pkg;

  // Frame geometry
  localparam int MAX_SIDE = 512;
  localparam int POS_W    = $clog2(MAX_SIDE);       // column / row index
  localparam int SE_W     = $clog2(MAX_SIDE + 1);   // holds MAX_SIDE itself
  localparam int SIDE_W   = 10;                     // side_in_use register
  localparam int CMP_W    = (SIDE_W > SE_W) ? SIDE_W : SE_W;

  // Fixed-point phase format
  localparam int PHASE_FRACTION_BITS = 12;
  localparam int PHASE_W = 15;                      // wrapped input sample
  localparam int RES_W   = 32;                      // unwrapped value

  // 2pi in Q.F, rounded to nearest, and pi rounded down
  localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
  localparam longint TWO_PI_Q =
    longint'((TWO_PI_Q32 + (64'd1 << (31 - PHASE_FRACTION_BITS)))
             >> (32 - PHASE_FRACTION_BITS));
  localparam longint HALF_PI2_Q = TWO_PI_Q / 2;

  // 2pi lies in [2^(F+2), 2^(F+3))
  localparam int TP_W = PHASE_FRACTION_BITS + 3;

  // Biased difference a = d + pi, wide enough for two 32-bit operands
  localparam int A_W   = 34;
  localparam int SUM_W = A_W + 2;

  // Whole number of turns just above 2^32, keeps the dividend non-negative
  localparam longint TURN_BIAS =
    ((longint'(1) << 32) + TWO_PI_Q - 1) / TWO_PI_Q * TWO_PI_Q;

  // Reciprocal reduction: 2pi = 8 * odd part (25736 = 8 * 3217 at Q.12),
  // so the quotient is (dividend >> 3) times a rounded-up reciprocal of the
  // odd part, exact for every dividend below 2^DVD_W
  localparam int     DVD_W       = A_W;
  localparam int     TP_SHIFT    = 3;
  localparam longint TP_ODD      = TWO_PI_Q >> TP_SHIFT;
  localparam int     NUM_W       = DVD_W - TP_SHIFT;
  localparam int     RECIP_SHIFT = NUM_W + $clog2(TP_ODD);
  localparam longint RECIP_M     =
    ((longint'(1) << RECIP_SHIFT) + TP_ODD - 1) / TP_ODD;
  localparam int     RECIP_W     = 32;
  localparam int     PROD_W      = NUM_W + RECIP_W;
  localparam int     QUO_W       = PROD_W - RECIP_SHIFT;

  // Per-step control from the sequencer
  typedef struct packed {
    logic accept;      // input transaction taken
    logic restart;     // frame restart after a side write
    logic row_zero;    // start of a row: clear row offset
    logic row_update;  // apply row correction
    logic row_value;   // form row-unwrapped value
    logic col_prep;    // form column difference
    logic col_zero;    // first row: clear column offset
    logic col_update;  // apply column correction
    logic col_write;   // write back line store entry
  } step_ctrl_t;

  // Clip to signed 32 bits
  function automatic logic signed [RES_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[SUM_W-1:RES_W-1];
    hi_zeros = ~|v[SUM_W-1:RES_W-1];
    if (hi_ones || hi_zeros) begin
      return v[RES_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      return {1'b0, {(RES_W-1){1'b1}}};
    end
  endfunction

  // off - k*2pi, where k*2pi = a - r with r the floored remainder of a
  function automatic logic signed [RES_W-1:0] offset_step(
    input logic signed [RES_W-1:0] off,
    input logic signed [A_W-1:0]   a,
    input logic [TP_W-1:0]         r
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(off) - SUM_W'(a) + $signed(SUM_W'(r));
    return sat32(s);
  endfunction

endpackage

// File: sv/purc_in_if.sv
// ----------------------------------------------------------------------------
// purc_in_if
// Valid/ready channel carrying one wrapped phase sample per transaction.
// ----------------------------------------------------------------------------
interface purc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [purc_pkg::PHASE_W-1:0]  wrapped_phase;

  modport source (output valid, output wrapped_phase, input ready);
  modport sink   (input valid, input wrapped_phase, output ready);
endinterface

// File: sv/purc_out_if.sv
// ----------------------------------------------------------------------------
// purc_out_if
// Valid/ready channel carrying one unwrapped phase value per transaction.
// ----------------------------------------------------------------------------
interface purc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [purc_pkg::RES_W-1:0]  unwrapped_phase;
  logic                               last_of_frame;

  modport source (output valid, output unwrapped_phase, output last_of_frame,
                  input ready);
  modport sink   (input valid, input unwrapped_phase, input last_of_frame,
                  output ready);
endinterface

// File: sv/purc_rem.sv
// ----------------------------------------------------------------------------
// purc_rem
// Floored remainder of a biased phase difference by 2pi, by reciprocal
// multiplication in three steps: capture, quotient, remainder.
// ----------------------------------------------------------------------------
module purc_rem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [purc_pkg::A_W-1:0]   a,
  output logic                              done,
  output logic [purc_pkg::TP_W-1:0]         rem
);

  logic signed [purc_pkg::A_W:0]     biased;
  logic [purc_pkg::DVD_W-1:0]        dvd;
  logic [purc_pkg::DVD_W-1:0]        dvd_q;
  logic [purc_pkg::PROD_W-1:0]       prod;
  logic [purc_pkg::QUO_W-1:0]        quo;
  logic                              quo_pending;
  logic                              rem_pending;

  // Whole turns added so the dividend never goes negative
  assign biased = (purc_pkg::A_W + 1)'(a) + (purc_pkg::A_W + 1)'(purc_pkg::TURN_BIAS);
  assign dvd    = biased[purc_pkg::DVD_W-1:0];

  // Dividend over 8 times the reciprocal of the odd part of 2pi
  assign prod = purc_pkg::PROD_W'(dvd_q[purc_pkg::DVD_W-1:purc_pkg::TP_SHIFT])
              * purc_pkg::PROD_W'(purc_pkg::RECIP_M);

  // Stage flags and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      quo_pending <= 1'b0;
      rem_pending <= 1'b0;
      done        <= 1'b0;
    end else begin
      quo_pending <= start;
      rem_pending <= quo_pending;
      done        <= rem_pending;
    end
  end

  // Dividend, quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_q <= dvd;
    end
    if (quo_pending) begin
      quo <= prod[purc_pkg::PROD_W-1:purc_pkg::RECIP_SHIFT];
    end
    if (rem_pending) begin
      rem <= purc_pkg::TP_W'(dvd_q - purc_pkg::DVD_W'(quo)
                                     * purc_pkg::DVD_W'(purc_pkg::TWO_PI_Q));
    end
  end

endmodule

// File: sv/purc_row.sv
// ----------------------------------------------------------------------------
// purc_row
// Row pass: previous sample, running row offset and the row-unwrapped value.
// ----------------------------------------------------------------------------
module purc_row (
  input  logic                                 clk,
  input  logic                                 rst,
  input  purc_pkg::step_ctrl_t                 ctrl,
  input  logic signed [purc_pkg::PHASE_W-1:0]  x,
  input  logic [purc_pkg::TP_W-1:0]            rem,
  output logic signed [purc_pkg::A_W-1:0]      row_a,
  output logic signed [purc_pkg::RES_W-1:0]    row_val
);

  logic signed [purc_pkg::PHASE_W-1:0]  prev_sample;
  logic signed [purc_pkg::PHASE_W-1:0]  cur_x;
  logic signed [purc_pkg::RES_W-1:0]    row_offset;

  // Row state, cleared at reset and frame restart
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      prev_sample <= '0;
      row_offset  <= '0;
    end else begin
      if (ctrl.accept) begin
        prev_sample <= x;
      end
      if (ctrl.row_zero) begin
        row_offset <= '0;
      end else if (ctrl.row_update) begin
        row_offset <= purc_pkg::offset_step(row_offset, row_a, rem);
      end
    end
  end

  // Neighbour difference plus pi, and the row value
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cur_x <= x;
      row_a <= purc_pkg::A_W'(x) - purc_pkg::A_W'(prev_sample)
             + purc_pkg::A_W'(purc_pkg::HALF_PI2_Q);
    end
    if (ctrl.row_value) begin
      row_val <= purc_pkg::sat32(purc_pkg::SUM_W'(cur_x) + purc_pkg::SUM_W'(row_offset));
    end
  end

endmodule

// File: sv/purc_col.sv
// ----------------------------------------------------------------------------
// purc_col
// Column pass: line store of previous row value and column offset per
// column, read at input acceptance and written back once per sample.
// ----------------------------------------------------------------------------
module purc_col (
  input  logic                                clk,
  input  purc_pkg::step_ctrl_t                ctrl,
  input  logic [purc_pkg::POS_W-1:0]          rd_addr,
  input  logic [purc_pkg::POS_W-1:0]          wr_addr,
  input  logic signed [purc_pkg::RES_W-1:0]   row_val,
  input  logic [purc_pkg::TP_W-1:0]           rem,
  output logic signed [purc_pkg::A_W-1:0]     col_a,
  output logic signed [purc_pkg::RES_W-1:0]   result
);

  logic [2*purc_pkg::RES_W-1:0]         line_mem [purc_pkg::MAX_SIDE];
  logic [2*purc_pkg::RES_W-1:0]         rd_q;
  logic signed [purc_pkg::RES_W-1:0]    mem_prev;
  logic signed [purc_pkg::RES_W-1:0]    mem_off;
  logic signed [purc_pkg::RES_W-1:0]    new_off;

  // Line store: {previous row value, column offset}
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      rd_q <= line_mem[rd_addr];
    end
    if (ctrl.col_write) begin
      line_mem[wr_addr] <= {row_val, new_off};
    end
  end

  assign mem_prev = rd_q[2*purc_pkg::RES_W-1:purc_pkg::RES_W];
  assign mem_off  = rd_q[purc_pkg::RES_W-1:0];

  // Column difference plus pi, and updated column offset
  always_ff @(posedge clk) begin
    if (ctrl.col_prep) begin
      col_a <= purc_pkg::A_W'(row_val) - purc_pkg::A_W'(mem_prev)
             + purc_pkg::A_W'(purc_pkg::HALF_PI2_Q);
    end
    if (ctrl.col_zero) begin
      new_off <= '0;
    end else if (ctrl.col_update) begin
      new_off <= purc_pkg::offset_step(mem_off, col_a, rem);
    end
  end

  assign result = purc_pkg::sat32(purc_pkg::SUM_W'(row_val) + purc_pkg::SUM_W'(new_off));

endmodule

// File: sv/phase_unwrap_rows_then_columns.sv
// ----------------------------------------------------------------------------
// phase_unwrap_rows_then_columns
// Two-dimensional Itoh phase unwrapper, rows first and then columns.
// ----------------------------------------------------------------------------
// Wrapped phase samples (signed radians, Q.12) of a square frame enter in
// row-major order, one per transaction, and each gives one unwrapped 32-bit
// value, saturated, with last_of_frame marking the final sample. The block
// handles one sample at a time: row reduction, row value, column difference,
// column reduction, then write-back to the line store and output register.
// A sample at the start of a row skips the row reduction and one on the
// first row skips the column reduction. The reduction by 2pi, a reciprocal
// multiplication, is shared by the row and column passes, around the line
// store read and write-back. The next sample is taken while the previous
// result still waits in the output register; it then holds before
// write-back until the register frees. The line store needs no
// initialisation: the first row of each frame writes every column.
// Writing side_in_use (byte address 0) restarts the frame; values below 2
// act as 2 and above 512 as 512.
// ----------------------------------------------------------------------------
module phase_unwrap_rows_then_columns (
  input  logic          clk,
  input  logic          rst,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // sample channels
  purc_in_if.sink       samples,
  purc_out_if.source    results
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_RWAIT = 3'd2;
  localparam logic [2:0] S_RVAL  = 3'd3;
  localparam logic [2:0] S_COLA  = 3'd4;
  localparam logic [2:0] S_CDIV  = 3'd5;
  localparam logic [2:0] S_CWAIT = 3'd6;
  localparam logic [2:0] S_CRES  = 3'd7;

  logic [2:0]                           state;
  logic [2:0]                           state_next;
  logic [purc_pkg::SIDE_W-1:0]          side_in_use;
  logic [purc_pkg::SE_W-1:0]            eff_side;
  logic [purc_pkg::CMP_W-1:0]           side_ext;
  logic [purc_pkg::POS_W-1:0]           col_pos;
  logic [purc_pkg::POS_W-1:0]           row_pos;
  logic [purc_pkg::SE_W-1:0]            col_inc;
  logic [purc_pkg::SE_W-1:0]            row_inc;
  logic [purc_pkg::POS_W-1:0]           cur_col;
  logic                                 first_col;
  logic                                 first_row;
  logic                                 cur_last;
  logic                                 cfg_wr;
  logic                                 accept;
  logic                                 out_free;
  logic                                 rem_start;
  logic                                 rem_done;
  logic [purc_pkg::TP_W-1:0]            rem;
  logic signed [purc_pkg::A_W-1:0]      row_a;
  logic signed [purc_pkg::A_W-1:0]      col_a;
  logic signed [purc_pkg::A_W-1:0]      rem_a;
  logic signed [purc_pkg::RES_W-1:0]    row_val;
  logic signed [purc_pkg::RES_W-1:0]    result;
  logic                                 out_valid;
  logic signed [purc_pkg::RES_W-1:0]    out_phase;
  logic                                 out_last;
  purc_pkg::step_ctrl_t                 ctrl;

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(side_in_use) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_in_use <= purc_pkg::SIDE_W'(purc_pkg::MAX_SIDE);
    end else if (cfg_wr && (paddr[2] == 1'b0)) begin
      side_in_use <= pwdata[purc_pkg::SIDE_W-1:0];
    end
  end

  // Effective side, clamped to [2, MAX_SIDE]
  always_comb begin
    side_ext = purc_pkg::CMP_W'(side_in_use);
    if (side_ext < purc_pkg::CMP_W'(2)) begin
      side_ext = purc_pkg::CMP_W'(2);
    end else if (side_ext > purc_pkg::CMP_W'(purc_pkg::MAX_SIDE)) begin
      side_ext = purc_pkg::CMP_W'(purc_pkg::MAX_SIDE);
    end
    eff_side = purc_pkg::SE_W'(side_ext);
  end

  // Frame position
  assign accept  = samples.valid && samples.ready;
  assign col_inc = purc_pkg::SE_W'(col_pos) + 1'b1;
  assign row_inc = purc_pkg::SE_W'(row_pos) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || (cfg_wr && (paddr[2] == 1'b0))) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_inc >= eff_side) begin
        col_pos <= '0;
        row_pos <= (row_inc >= eff_side) ? '0 : row_inc[purc_pkg::POS_W-1:0];
      end else begin
        col_pos <= col_inc[purc_pkg::POS_W-1:0];
      end
    end
  end

  // Position of the sample in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col   <= col_pos;
      first_col <= (col_pos == '0);
      first_row <= (row_pos == '0);
      cur_last  <= (col_inc == eff_side) && (row_inc == eff_side);
    end
  end

  // Sequencer
  assign out_free = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_ROW;
      S_ROW:   state_next = first_col ? S_RVAL : S_RWAIT;
      S_RWAIT: if (rem_done) state_next = S_RVAL;
      S_RVAL:  state_next = S_COLA;
      S_COLA:  state_next = first_row ? S_CRES : S_CDIV;
      S_CDIV:  state_next = S_CWAIT;
      S_CWAIT: if (rem_done) state_next = S_CRES;
      S_CRES:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign samples.ready = (state == S_IDLE);

  // Step controls
  always_comb begin
    ctrl            = '0;
    ctrl.accept     = accept;
    ctrl.restart    = cfg_wr && (paddr[2] == 1'b0);
    ctrl.row_zero   = (state == S_ROW) && first_col;
    ctrl.row_update = (state == S_RWAIT) && rem_done;
    ctrl.row_value  = (state == S_RVAL);
    ctrl.col_prep   = (state == S_COLA);
    ctrl.col_zero   = (state == S_COLA) && first_row;
    ctrl.col_update = (state == S_CWAIT) && rem_done;
    ctrl.col_write  = (state == S_CRES) && out_free;
  end

  // Shared reduction unit: row difference first, then column difference
  assign rem_start = ((state == S_ROW) && !first_col) || (state == S_CDIV);
  assign rem_a     = (state == S_CDIV) ? col_a : row_a;

  purc_rem u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .a     (rem_a),
    .done  (rem_done),
    .rem   (rem)
  );

  purc_row u_row (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .x       (samples.wrapped_phase),
    .rem     (rem),
    .row_a   (row_a),
    .row_val (row_val)
  );

  purc_col u_col (
    .clk     (clk),
    .ctrl    (ctrl),
    .rd_addr (col_pos),
    .wr_addr (cur_col),
    .row_val (row_val),
    .rem     (rem),
    .col_a   (col_a),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.col_write) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.col_write) begin
      out_phase <= result;
      out_last  <= cur_last;
    end
  end

  assign results.valid           = out_valid;
  assign results.unwrapped_phase = out_phase;
  assign results.last_of_frame   = out_last;

endmodule

// File: verif/phase_unwrap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_unwrap_checker
// Watches the sample channels and the register port of the row-then-column
// phase unwrapper, predicts each unwrapped value and compares it on arrival.
// ----------------------------------------------------------------------------
module phase_unwrap_checker #(
  parameter logic [2:0] SIDE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  purc_in_if          samples,
  purc_out_if         results,
  output int          mismatches,
  output int          outstanding
);
  import purc_pkg::*;

  // 2pi in Q.12 rounded to nearest, and pi rounded down
  localparam longint FULL_TURN = 64'sd25736;
  localparam longint HALF_TURN = FULL_TURN / 2;
  localparam longint INT32_HI  = 64'sd2147483647;
  localparam longint INT32_LO  = -64'sd2147483648;

  typedef struct packed {
    logic signed [RES_W-1:0] unwrapped_phase;
    logic                    last_of_frame;
  } unwrap_result_t;

  // Mirror of the unwrapper state
  logic [SIDE_W-1:0]       side_reg;
  logic signed [31:0]      prev_sample;
  logic signed [31:0]      row_off;
  int unsigned             col_pos;
  int unsigned             row_pos;
  logic signed [31:0]      col_prev [MAX_SIDE];
  logic signed [31:0]      col_off  [MAX_SIDE];

  unwrap_result_t expected_unwrapped [$];
  int             fail_count;

  assign mismatches = fail_count;

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > INT32_HI) return INT32_HI[31:0];
    if (v < INT32_LO) return INT32_LO[31:0];
    return v[31:0];
  endfunction

  // Whole turns that bring d into [-pi, pi), floored
  function automatic longint whole_turns(input longint d);
    longint a;
    longint q;
    a = d + HALF_TURN;
    q = a / FULL_TURN;
    if ((a % FULL_TURN) != 0 && a < 0) q--;
    return q;
  endfunction

  // Row pass, then column pass through the line store; advances position
  function automatic unwrap_result_t unwrap_next_sample(
    input logic signed [PHASE_W-1:0] x
  );
    int unsigned        eff;
    int unsigned        c;
    int unsigned        r;
    longint             xs;
    longint             k;
    logic signed [31:0] row_val;
    unwrap_result_t     res;
    eff = (side_reg < 2) ? 2 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
    c = (col_pos >= eff) ? 0 : col_pos;
    r = (row_pos >= eff) ? 0 : row_pos;
    xs = longint'(x);

    if (c == 0) begin
      row_off = '0;
    end else begin
      k = whole_turns(xs - longint'(prev_sample));
      row_off = clip32(longint'(row_off) - k * FULL_TURN);
    end
    prev_sample = x;
    row_val = clip32(xs + longint'(row_off));

    if (r == 0) begin
      col_off[c] = '0;
      res.unwrapped_phase = row_val;
    end else begin
      k = whole_turns(longint'(row_val) - longint'(col_prev[c]));
      col_off[c] = clip32(longint'(col_off[c]) - k * FULL_TURN);
      res.unwrapped_phase = clip32(longint'(row_val) + longint'(col_off[c]));
    end
    col_prev[c] = row_val;
    res.last_of_frame = (c == eff - 1) && (r == eff - 1);

    if (c + 1 >= eff) begin
      c = 0;
      r = (r + 1 >= eff) ? 0 : r + 1;
    end else begin
      c++;
    end
    col_pos = c;
    row_pos = r;
    return res;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    unwrap_result_t want;
    if (rst) begin
      side_reg    = SIDE_W'(MAX_SIDE);
      prev_sample = '0;
      row_off     = '0;
      col_pos     = 0;
      row_pos     = 0;
      for (int i = 0; i < MAX_SIDE; i++) begin
        col_prev[i] = '0;
        col_off[i]  = '0;
      end
      expected_unwrapped.delete();
      fail_count = 0;
    end else begin
      // side write restarts the frame; other addresses are ignored
      if (psel && penable && pwrite && pready && paddr == SIDE_ADDR) begin
        side_reg    = pwdata[SIDE_W-1:0];
        prev_sample = '0;
        row_off     = '0;
        col_pos     = 0;
        row_pos     = 0;
      end

      if (samples.valid && samples.ready)
        expected_unwrapped.push_back(unwrap_next_sample(samples.wrapped_phase));

      if (results.valid && results.ready) begin
        if (expected_unwrapped.size() == 0) begin
          $display("%0t: unexpected result transaction, got unwrapped_phase %0d last %0b",
                   $time, results.unwrapped_phase, results.last_of_frame);
          fail_count++;
        end else begin
          want = expected_unwrapped.pop_front();
          if (results.unwrapped_phase !== want.unwrapped_phase) begin
            $display("%0t: unwrapped_phase expected %0d, got %0d",
                     $time, want.unwrapped_phase, results.unwrapped_phase);
            fail_count++;
          end
          if (results.last_of_frame !== want.last_of_frame) begin
            $display("%0t: last_of_frame expected %0b, got %0b",
                     $time, want.last_of_frame, results.last_of_frame);
            fail_count++;
          end
        end
      end
    end
    outstanding <= expected_unwrapped.size();
  end

endmodule

// File: verif/phase_unwrap_rows_then_columns_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_unwrap_rows_then_columns_tb
// Drives wrapped phase frames of many sizes through the unwrapper, with
// random gaps and stalls on both channels, and reports the checker verdict.
// ----------------------------------------------------------------------------
module phase_unwrap_rows_then_columns_tb;
  import purc_pkg::*;

  localparam logic [2:0] SIDE_ADDR       = 3'd0;
  localparam logic [2:0] UNUSED_ADDR     = 3'd4;
  localparam int         STALL_LIMIT     = 5000;
  localparam int         SETTLE_CYCLES   = 150;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         TARGET_ITEMS    = 1850;
  localparam int         FULL_ROW_ITEMS  = 530;

  // side written per phase: undersized, oversized and all-ones included
  localparam int PHASE_SIDES [20] = '{1, 4, 0, 2, 1023, 3, 7, 513, 16, 5,
                                      8, 31, 6, 2, 12, 9, 4, 23, 3, 11};

  // field extremes and the turn boundaries of a neighbour difference
  localparam int DIRECTED_ROW [14] = '{0, 16383, -16384, 16383, -16384, -1, 0,
                                       12867, 0, 12868, 0, -12869, 21845, 10922};
  localparam int DIRECTED_SQUARE [8] = '{0, 0, 16383, -16384,
                                         -16384, 16383, 0, 0};

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int samples_sent;
  int idle_cycles;
  bit gaps_on;
  bit hold_off_req;

  purc_in_if  samples ();
  purc_out_if results ();

  phase_unwrap_rows_then_columns dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samples),
    .results (results)
  );

  phase_unwrap_checker #(.SIDE_ADDR(SIDE_ADDR)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .samples     (samples),
    .results     (results),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, or one long hold-off on request
  initial begin
    bit hold_off_done;
    hold_off_done = 1'b0;
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        results.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
        results.ready <= 1'b1;
      end else begin
        results.ready <= !(gaps_on && $urandom_range(99) < 10);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)
        || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("phase_unwrap_rows_then_columns_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One input transaction, with an occasional gap before it
  task automatic send_sample(input logic signed [PHASE_W-1:0] x);
    if (gaps_on && $urandom_range(99) < 10) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    samples.valid         <= 1'b1;
    samples.wrapped_phase <= x;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // Stop offering and wait for every predicted result
  task automatic wait_drained();
    samples.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic signed [PHASE_W-1:0] wrap_to_pi(input longint t);
    longint m;
    m = (t + TWO_PI_Q / 2) % TWO_PI_Q;
    if (m < 0) m += TWO_PI_Q;
    return PHASE_W'(m - TWO_PI_Q / 2);
  endfunction

  // A phase: smooth tilted surfaces, wrapped, with some uniform noise
  task automatic run_phase(input int side_value, input int count, input int pause_at);
    int     eff;
    int     base;
    int     sx;
    int     sy;
    int     c;
    int     r;
    longint t;
    logic signed [PHASE_W-1:0] x;
    write_reg(SIDE_ADDR, 32'(side_value));
    eff  = (side_value < 2) ? 2 : ((side_value > MAX_SIDE) ? MAX_SIDE : side_value);
    base = int'($urandom_range(200000)) - 100000;
    sx   = int'($urandom_range(24000)) - 12000;
    sy   = int'($urandom_range(24000)) - 12000;
    for (int i = 0; i < count; i++) begin
      c = i % eff;
      r = (i / eff) % eff;
      if (i == pause_at) wait_drained();
      if ($urandom_range(99) < 20) begin
        x = PHASE_W'($urandom);
      end else begin
        t = longint'(base) + longint'(sx) * c + longint'(sy) * r
            + int'($urandom_range(1000)) - 500;
        x = wrap_to_pi(t);
      end
      send_sample(x);
    end
    wait_drained();
  endtask

  // Stimulus and verdict
  initial begin
    int side_value;
    int eff;
    int cap;
    int count;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    samples.valid         = 1'b0;
    samples.wrapped_phase = '0;
    gaps_on               = 1'b1;
    hold_off_req          = 1'b0;
    samples_sent          = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First row at the reset side: extremes and turn boundaries
    foreach (DIRECTED_ROW[i]) send_sample(PHASE_W'(DIRECTED_ROW[i]));
    wait_drained();
    // unknown register: the row must carry on
    write_reg(UNUSED_ADDR, 32'hFFFF_FFFF);
    send_sample(PHASE_W'(16383));
    send_sample(PHASE_W'(-16384));
    wait_drained();
    // smallest frame, twice: column pass and frame end
    write_reg(SIDE_ADDR, 32'd2);
    foreach (DIRECTED_SQUARE[i]) send_sample(PHASE_W'(DIRECTED_SQUARE[i]));
    wait_drained();

    // Fixed phase list, then random sides until the item budget is used
    for (int p = 0; samples_sent < TARGET_ITEMS; p++) begin
      if (p < 20) begin
        side_value = PHASE_SIDES[p];
      end else begin
        side_value = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 24);
      end
      eff   = (side_value < 2) ? 2 : ((side_value > MAX_SIDE) ? MAX_SIDE : side_value);
      cap   = (3 * eff * eff < 120) ? 3 * eff * eff : 120;
      count = $urandom_range(1, cap);
      if (side_value == 1023) count = FULL_ROW_ITEMS;
      // long receiver hold-off while the full-width row streams in
      if (p == 4) hold_off_req = 1'b1;
      // a stretch with no idling on either side
      gaps_on = !(p >= 9 && p <= 11);
      // sender pauses mid-frame until all results are back
      run_phase(side_value, count, (p == 6) ? count / 2 : -1);
    end
    gaps_on = 1'b1;

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("phase_unwrap_rows_then_columns_tb OK");
    end else begin
      $display("phase_unwrap_rows_then_columns_tb NOT OK");
    end
    $finish;
  end

endmodule
